// ===== src/cprpm_pkg.sv =====
// shared widths, reset values and register indexes for the period to rpm meter
`timescale 1ns / 1ps
`default_nettype none
package cprpm_pkg;

  // fixed field widths
  localparam int CAP_W    = 16;
  localparam int PERIOD_W = 32;
  localparam int FREQ_W   = 32;
  localparam int RPM_W    = 40;
  localparam int CLK_W    = 32;
  localparam int DIV_W    = 16;
  localparam int MULT_W   = 8;
  localparam int PROD_W   = PERIOD_W + DIV_W;
  localparam int OUT_DATA_W = PERIOD_W + FREQ_W + RPM_W;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // default timer geometry
  localparam int COUNTER_WIDTH_DEF  = 16;
  localparam int OVERFLOW_WIDTH_DEF = 16;

  // register reset values
  localparam logic [CLK_W-1:0]  CLOCK_HZ_RST       = 32'd168000000;
  localparam logic [DIV_W-1:0]  FREQ_DIVISOR_RST   = 16'd100;
  localparam logic [MULT_W-1:0] RPM_MULTIPLIER_RST = 8'd20;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CLOCK_HZ       = 2'd0,
    REG_FREQ_DIVISOR   = 2'd1,
    REG_RPM_MULTIPLIER = 2'd2
  } cfg_reg_t;

  // event kinds on the input tuser bit
  localparam logic CMD_OVERFLOW = 1'b0;
  localparam logic CMD_CAPTURE  = 1'b1;

endpackage
`default_nettype wire

// ===== src/cprpm_div.sv =====
// bit-serial restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module cprpm_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [cprpm_pkg::CLK_W-1:0]   dividend,
  input  wire logic [cprpm_pkg::PERIOD_W-1:0] period,
  input  wire logic [cprpm_pkg::DIV_W-1:0]   divisor,
  output logic                               done,
  output logic [cprpm_pkg::CLK_W-1:0]        quotient
);
  import cprpm_pkg::*;

  localparam int CNT_W = $clog2(CLK_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CLK_W - 1);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [CLK_W-1:0]    acc_r, acc_nxt;
  logic [CLK_W-1:0]    rem_r, rem_nxt;
  logic [PROD_W-1:0]   dsr_r, dsr_nxt;

  logic [DIV_W-1:0]    div_eff;
  logic [CLK_W:0]      trial;
  logic                ge;

  // a zero divisor register acts as one
  assign div_eff = (divisor == '0) ? DIV_W'(1) : divisor;
  assign trial   = {rem_r, acc_r[CLK_W-1]};
  assign ge      = PROD_W'(trial) >= dsr_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      // clock / period / divisor equals clock / (period * divisor)
      dsr_nxt  = PROD_W'(period) * PROD_W'(div_eff);
      acc_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = {acc_r[CLK_W-2:0], ge};
      rem_nxt = ge ? CLK_W'(PROD_W'(trial) - dsr_r) : trial[CLK_W-1:0];
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done     = done_r;
  assign quotient = acc_r;

endmodule
`default_nettype wire

// ===== src/capture_period_to_rpm_top.sv =====
// top level of the input capture period to frequency and rpm meter
//
// input channel: in_tuser is the event kind (overflow or capture edge), in_tdata
// carries the captured counter value. overflows and the first capture of a pair
// are absorbed in the cycle they are taken and give no item out.
// the second capture of a pair gives one item on the output channel: period in
// ticks, frequency, rpm, and in out_tuser a flag for a zero period.
// path from the second capture to out_tvalid: the divisor product at the divider
// start, the bit-serial divider (one quotient bit per cycle over 32 bits), the
// rpm product and the output load. a zero period skips the divider and goes
// straight to the output load.
// throughput: events without a result are taken every cycle; after a second
// capture the next item is taken once the result sits in the output register.
// config writes (cfg_valid/cfg_ready) are always taken, meant for idle times.
// reset (synchronous, rst_n low) disarms the block, clears the overflow count
// and loads the default register values.
// a stalled receiver holds the result in the output register; the block goes
// on taking items and only waits if a further result is ready before then.
`timescale 1ns / 1ps
`default_nettype none
module capture_period_to_rpm_top #(
  parameter int COUNTER_WIDTH  = cprpm_pkg::COUNTER_WIDTH_DEF,
  parameter int OVERFLOW_WIDTH = cprpm_pkg::OVERFLOW_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // input channel
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [cprpm_pkg::CAP_W-1:0]       in_tdata,  // [15:0] capture_value
  input  wire logic                              in_tuser,  // [0] cmd
  // result channel
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [31:0] period_ticks, [63:32] frequency, [103:64] rpm
  output logic [cprpm_pkg::OUT_DATA_W-1:0]       out_tdata,
  output logic                                   out_tuser, // [0] zero_period
  // configuration write channel
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [cprpm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [cprpm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import cprpm_pkg::*;

  // span of a pair is the overflow count above the counter difference
  localparam int SPAN_W = OVERFLOW_WIDTH + COUNTER_WIDTH;
  localparam int EXT_W  = (SPAN_W > PERIOD_W) ? SPAN_W : PERIOD_W + 1;
  localparam int CAPX_W = (COUNTER_WIDTH > CAP_W) ? COUNTER_WIDTH : CAP_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_WAIT = 4'b0100,
    S_PUSH = 4'b1000
  } state_t;

  state_t                     state_r, state_nxt;

  // configuration registers
  logic [CLK_W-1:0]           clock_hz_r;
  logic [DIV_W-1:0]           freq_div_r;
  logic [MULT_W-1:0]          rpm_mult_r;

  // pairing state
  logic                       armed_r, armed_nxt;
  logic [COUNTER_WIDTH-1:0]   first_r, first_nxt;
  logic [OVERFLOW_WIDTH-1:0]  ovf_r, ovf_nxt;

  // result being built
  logic [PERIOD_W-1:0]        period_r, period_nxt;
  logic                       zero_r, zero_nxt;
  logic [FREQ_W-1:0]          freq_r, freq_nxt;
  logic [RPM_W-1:0]           rpm_r, rpm_nxt;

  // output register
  logic                       out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0]      out_data_r, out_data_nxt;
  logic                       out_zero_r, out_zero_nxt;

  logic                       in_fire;
  logic [CAPX_W-1:0]          cap_x;
  logic [COUNTER_WIDTH-1:0]   cap_c;
  logic [COUNTER_WIDTH-1:0]   diff;
  logic [EXT_W-1:0]           span_ext;
  logic [PERIOD_W-1:0]        period_sat;
  logic                       div_start;
  logic                       div_done;
  logic [CLK_W-1:0]           div_quot;
  logic                       out_free;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_tready;

  // only the low counter bits of a capture take part
  assign cap_x    = CAPX_W'(in_tdata);
  assign cap_c    = cap_x[COUNTER_WIDTH-1:0];
  assign diff     = cap_c - first_r;
  assign span_ext = EXT_W'({ovf_r, diff});
  // saturate a span that does not fit the period field
  assign period_sat = (|span_ext[EXT_W-1:PERIOD_W]) ? '1 : span_ext[PERIOD_W-1:0];

  assign div_start = (state_r == S_DIV);

  cprpm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (clock_hz_r),
    .period   (period_r),
    .divisor  (freq_div_r),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_comb begin
    state_nxt     = state_r;
    armed_nxt     = armed_r;
    first_nxt     = first_r;
    ovf_nxt       = ovf_r;
    period_nxt    = period_r;
    zero_nxt      = zero_r;
    freq_nxt      = freq_r;
    rpm_nxt       = rpm_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_zero_nxt  = out_zero_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_tuser == CMD_OVERFLOW) begin
            // overflow count saturates at all ones, ignored while disarmed
            if (armed_r && (ovf_r != '1)) begin
              ovf_nxt = ovf_r + OVERFLOW_WIDTH'(1);
            end
          end else if (!armed_r) begin
            first_nxt = cap_c;
            armed_nxt = 1'b1;
          end else begin
            armed_nxt  = 1'b0;
            ovf_nxt    = '0;
            period_nxt = period_sat;
            zero_nxt   = (period_sat == '0);
            freq_nxt   = '0;
            rpm_nxt    = '0;
            // a zero period skips the divider with zero results
            state_nxt  = (period_sat == '0) ? S_PUSH : S_DIV;
          end
        end
      end
      S_DIV: begin
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (div_done) begin
          freq_nxt  = div_quot;
          rpm_nxt   = RPM_W'(div_quot) * RPM_W'(rpm_mult_r);
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {rpm_r, freq_r, period_r};
          out_zero_nxt  = zero_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      armed_r     <= 1'b0;
      first_r     <= '0;
      ovf_r       <= '0;
      out_valid_r <= 1'b0;
      clock_hz_r  <= CLOCK_HZ_RST;
      freq_div_r  <= FREQ_DIVISOR_RST;
      rpm_mult_r  <= RPM_MULTIPLIER_RST;
    end else begin
      state_r     <= state_nxt;
      armed_r     <= armed_nxt;
      first_r     <= first_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CLOCK_HZ:       clock_hz_r <= cfg_data[CLK_W-1:0];
          REG_FREQ_DIVISOR:   freq_div_r <= cfg_data[DIV_W-1:0];
          REG_RPM_MULTIPLIER: rpm_mult_r <= cfg_data[MULT_W-1:0];
          default: begin
          end
        endcase
      end
    end
    period_r   <= period_nxt;
    zero_r     <= zero_nxt;
    freq_r     <= freq_nxt;
    rpm_r      <= rpm_nxt;
    out_data_r <= out_data_nxt;
    out_zero_r <= out_zero_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_zero_r;

endmodule
`default_nettype wire

// ===== verif/tb_capture_period_to_rpm_top.sv =====
// self-checking testbench for the capture period to frequency and rpm meter
`timescale 1ns / 1ps
module tb_capture_period_to_rpm_top;
  import cprpm_pkg::*;

  // no item accepted on any channel for this many cycles ends the run
  localparam int IDLE_LIMIT    = 4000;
  // quiet cycles after the last reading, longer than the divider latency
  localparam int SETTLE_CYCLES = 60;
  // cycles the receiver holds off once to back the block up
  localparam int HOLD_CYCLES   = 400;

  // one expected reading, laid out as {out_tuser, out_tdata}
  typedef struct packed {
    logic              zero_period;
    logic [RPM_W-1:0]    rpm;
    logic [FREQ_W-1:0]   frequency;
    logic [PERIOD_W-1:0] period;
  } reading_t;

  // mirror of the meter: registers, pairing state and the readings still due
  class rpm_meter_model;
    logic [CLK_W-1:0]  clock_hz;
    logic [DIV_W-1:0]  freq_div;
    logic [MULT_W-1:0] rpm_mult;
    bit                armed;
    logic [CAP_W-1:0]  first_cap;
    logic [OVERFLOW_WIDTH_DEF-1:0] ovf_count;
    reading_t          readings_due[$];
    int                errors;

    function new();
      clock_hz  = CLOCK_HZ_RST;
      freq_div  = FREQ_DIVISOR_RST;
      rpm_mult  = RPM_MULTIPLIER_RST;
      armed     = 1'b0;
      first_cap = '0;
      ovf_count = '0;
      errors    = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_CLOCK_HZ:       clock_hz = value[CLK_W-1:0];
        REG_FREQ_DIVISOR:   freq_div = value[DIV_W-1:0];
        REG_RPM_MULTIPLIER: rpm_mult = value[MULT_W-1:0];
        default: ;
      endcase
    endfunction

    // called for every accepted input item
    function void take_event(logic cmd, logic [CAP_W-1:0] cap);
      logic [CAP_W-1:0]    diff;
      logic [63:0]         span;
      logic [63:0]         freq;
      logic [DIV_W-1:0]    div;
      logic [PERIOD_W-1:0] period;
      reading_t            rd;
      if (cmd == CMD_OVERFLOW) begin
        if (armed && ovf_count != '1) ovf_count = ovf_count + 1'b1;
        return;
      end
      if (!armed) begin
        first_cap = cap;
        armed     = 1'b1;
        return;
      end
      diff   = cap - first_cap;
      span   = ({48'b0, ovf_count} << CAP_W) + {48'b0, diff};
      period = (span > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : span[PERIOD_W-1:0];
      armed     = 1'b0;
      ovf_count = '0;
      if (period == '0) begin
        rd = '{zero_period: 1'b1, rpm: '0, frequency: '0, period: '0};
      end else begin
        // zero divisor register behaves as one
        div  = (freq_div == '0) ? 16'd1 : freq_div;
        freq = ({32'b0, clock_hz} / {32'b0, period}) / {48'b0, div};
        rd.zero_period = 1'b0;
        rd.period      = period;
        rd.frequency   = freq[FREQ_W-1:0];
        rd.rpm         = {8'b0, freq[FREQ_W-1:0]} * {32'b0, rpm_mult};
      end
      readings_due.push_back(rd);
    endfunction

    function void report(string what, logic [63:0] want, logic [63:0] got);
      if (errors < 25)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      errors++;
    endfunction

    // called for every accepted output item
    function void check_reading(logic [OUT_DATA_W-1:0] data, logic zero);
      reading_t want;
      if (readings_due.size() == 0) begin
        if (errors < 25)
          $display("%0t: unexpected reading, actual period %0d", $time, data[31:0]);
        errors++;
        return;
      end
      want = readings_due.pop_front();
      if (data[31:0] !== want.period)     report("period", want.period, data[31:0]);
      if (data[63:32] !== want.frequency) report("frequency", want.frequency, data[63:32]);
      if (data[103:64] !== want.rpm)      report("rpm", want.rpm, data[103:64]);
      if (zero !== want.zero_period)      report("zero_period", want.zero_period, zero);
    endfunction
  endclass

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [CAP_W-1:0]      in_tdata   = '0;     // [15:0] capture_value
  logic                  in_tuser   = 1'b0;   // [0] cmd
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;           // [31:0] period, [63:32] freq, [103:64] rpm
  logic                  out_tuser;           // [0] zero_period
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  rpm_meter_model meter = new();

  // modes shared between the sender and the receiver process
  bit quiet_mode = 1'b0;   // no gaps on either side
  bit hold_req   = 1'b0;   // receiver holds off for a long stretch
  int idle_cycles = 0;

  capture_period_to_rpm_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(99, 0);
    if (quiet_mode || r < 50) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  // offer one item and wait for it to be taken; valid stays high afterwards
  task automatic send_event(logic cmd, logic [CAP_W-1:0] cap);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= cap;
    do @(posedge clk); while (!in_tready);
    meter.take_event(cmd, cap);
  endtask

  // a well formed pair: capture, some overflows, capture
  task automatic run_pair(logic [CAP_W-1:0] first, int n_ovf, logic [CAP_W-1:0] second);
    send_event(CMD_CAPTURE, first);
    repeat (n_ovf) send_event(CMD_OVERFLOW, CAP_W'($urandom));
    send_event(CMD_CAPTURE, second);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    meter.set_reg(idx, value);
  endtask

  // only called once the block is idle
  task automatic write_settings(logic [31:0] hz, logic [15:0] div, logic [7:0] mult);
    write_reg(REG_CLOCK_HZ, hz);
    write_reg(REG_FREQ_DIVISOR, {16'b0, div});
    write_reg(REG_RPM_MULTIPLIER, {24'b0, mult});
    cfg_valid <= 1'b0;
  endtask

  // wait for every reading due, then let the divider run dry
  task automatic settle();
    in_tvalid <= 1'b0;
    while (meter.readings_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // mostly well formed pairs with random content, some stray and lone events
  task automatic run_random_phase(int n_items);
    int done;
    int r;
    int k;
    logic [CAP_W-1:0] first;
    done = 0;
    while (done < n_items) begin
      quiet_mode = (done >= 200 && done < 260);
      r = $urandom_range(99, 0);
      if (r < 85) begin
        k = $urandom_range(99, 0);
        if (k < 70)      k = $urandom_range(2, 0);
        else if (k < 95) k = $urandom_range(10, 3);
        else             k = $urandom_range(40, 11);
        first = CAP_W'($urandom);
        // a repeated value with no overflows gives a zero period
        if (r < 5) run_pair(first, 0, first);
        else       run_pair(first, k, CAP_W'($urandom));
        done += (r < 5) ? 2 : k + 2;
      end else if (r < 92) begin
        // overflow outside a pair is ignored and not counted
        if (meter.armed) done++;
        send_event(CMD_OVERFLOW, CAP_W'($urandom));
      end else begin
        // lone capture, pairs with whatever capture comes next
        send_event(CMD_CAPTURE, CAP_W'($urandom));
        done++;
      end
    end
    quiet_mode = 1'b0;
  endtask

  // receiver: random ready stretches, one long hold-off on request
  initial begin : receiver
    int len;
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (quiet_mode) begin
        out_tready <= 1'b1;
        @(posedge clk);
      end else begin
        len = ($urandom_range(19, 0) == 0) ? $urandom_range(80, 20) : $urandom_range(4, 1);
        out_tready <= ($urandom_range(3, 0) != 0);
        repeat (len) @(posedge clk);
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) meter.check_reading(out_tdata, out_tuser);
  end

  // watchdog on cycles with no handshake anywhere
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_capture_period_to_rpm_top failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed checks under the reset register values
    send_event(CMD_OVERFLOW, 16'hFFFF);      // overflow while not armed, ignored
    run_pair(16'h0000, 0, 16'h0000);         // zero period
    run_pair(16'hFFFF, 0, 16'h0000);         // counter wrap, period of one
    run_pair(16'h0000, 0, 16'hFFFF);         // largest span without overflow
    run_pair(16'h1234, 2, 16'h1233);         // overflows plus a wrapped difference
    run_pair(16'h8000, 1, 16'h8000);         // exactly one counter turn
    settle();

    // extremes of the registers
    write_settings(32'hFFFF_FFFF, 16'd1, 8'd255);
    run_pair(16'h0000, 0, 16'h0001);         // top frequency and rpm
    run_pair(16'h5555, 0, 16'hAAAA);
    settle();
    write_settings(32'd1, 16'hFFFF, 8'd0);
    run_pair(16'h0000, 0, 16'h0001);
    settle();
    write_settings(32'd1000000, 16'd0, 8'd7); // zero divisor behaves as one
    run_pair(16'h0010, 0, 16'h0013);
    settle();

    // random phases over several register settings
    write_settings(CLOCK_HZ_RST, FREQ_DIVISOR_RST, RPM_MULTIPLIER_RST);
    hold_req = 1'b1;                          // back the block up early on
    run_random_phase(370);
    settle();
    write_settings(32'hFFFF_FFFF, 16'd1, 8'd255);
    run_random_phase(370);
    settle();
    write_settings(32'd1, 16'hFFFF, 8'd0);
    run_random_phase(370);
    settle();
    write_settings($urandom_range(32'hFFFF_FFFF, 1), 16'($urandom_range(65535, 1)),
                   8'($urandom_range(255, 0)));
    run_random_phase(370);
    settle();
    write_settings($urandom_range(32'hFFFF_FFFF, 1), 16'($urandom_range(200, 1)),
                   8'($urandom_range(255, 0)));
    run_random_phase(370);
    settle();

    if (meter.errors == 0 && meter.readings_due.size() == 0) begin
      $display("tb_capture_period_to_rpm_top passed");
    end else begin
      $display("tb_capture_period_to_rpm_top failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/cprpm_pkg.sv
src/cprpm_div.sv
src/capture_period_to_rpm_top.sv
verif/tb_capture_period_to_rpm_top.sv
